// ===== hw/rtl/sst_pkg.sv =====
// Shared types, widths and codes for the sensor slot table.
package sst_pkg;

  localparam int ID_W       = 16;
  localparam int TEMP_W     = 16;
  localparam int HUM_W      = 14;
  localparam int TS_W       = 32;
  localparam int STATUS_W   = 3;
  localparam int SLOT_IDX_W = 6;
  localparam int SLOTS_DEF  = 16;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_DELETE = 1'b1
  } sst_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_UPDATED   = 3'd0,
    STAT_ADDED     = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_DELETED   = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } sst_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_RESOLVE,
    S_WRITE
  } sst_state_t;

  typedef struct packed {
    logic                     command;
    logic [ID_W-1:0]          device_id;
    logic [ID_W-1:0]          new_id;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [HUM_W-1:0]         humidity_centi;
    logic [TS_W-1:0]          timestamp;
  } sst_item_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]  humidity;
    logic [TS_W-1:0]   timestamp;
  } sst_data_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  free;
    logic [SLOT_IDX_W-1:0] free_idx;
  } sst_lookup_t;

  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [ID_W-1:0]       id;
  } sst_id_wr_t;

endpackage

// ===== hw/rtl/sst_if.sv =====
// Valid/ready channel interfaces for update items and result beats.
interface sst_in_if;
  logic                              valid;
  logic                              ready;
  logic                              command;
  logic [sst_pkg::ID_W-1:0]          device_id;
  logic [sst_pkg::ID_W-1:0]          new_id;
  logic signed [sst_pkg::TEMP_W-1:0] temperature_centi;
  logic [sst_pkg::HUM_W-1:0]         humidity_centi;
  logic [sst_pkg::TS_W-1:0]          timestamp;

  modport source (output valid, command, device_id, new_id, temperature_centi,
                  humidity_centi, timestamp, input ready);
  modport sink   (input valid, command, device_id, new_id, temperature_centi,
                  humidity_centi, timestamp, output ready);
endinterface

interface sst_out_if;
  logic                           valid;
  logic                           ready;
  logic [sst_pkg::STATUS_W-1:0]   status;
  logic [sst_pkg::SLOT_IDX_W-1:0] slot_index;

  modport source (output valid, status, slot_index, input ready);
  modport sink   (input valid, status, slot_index, output ready);
endinterface

// ===== hw/rtl/sst_slot_ids.sv =====
// Slot id cells: parallel compare against key and zero, registered, then priority encode.
module sst_slot_ids #(
  parameter int SLOTS = sst_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [sst_pkg::ID_W-1:0] key,
  input  sst_pkg::sst_id_wr_t      id_wr,
  output sst_pkg::sst_lookup_t     lookup
);
  import sst_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [ID_W-1:0]  ids_r [SLOTS];
  logic [SLOTS-1:0] match_r;
  logic [SLOTS-1:0] free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) ids_r[i] <= '0;
    end else if (id_wr.en) begin
      ids_r[id_wr.idx[IDX_W-1:0]] <= id_wr.id;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      match_r[i] <= (ids_r[i] == key);
      free_r[i]  <= (ids_r[i] == '0);
    end
  end

  // lowest set bit wins
  always_comb begin
    lookup = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        lookup.hit     = 1'b1;
        lookup.hit_idx = SLOT_IDX_W'(i);
      end
      if (free_r[i]) begin
        lookup.free     = 1'b1;
        lookup.free_idx = SLOT_IDX_W'(i);
      end
    end
  end

endmodule

// ===== hw/rtl/sst_slot_data.sv =====
// Reading store: synchronous RAM with per-entry valid bits and field-wise merge on write-back.
module sst_slot_data #(
  parameter int SLOTS = sst_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [sst_pkg::SLOT_IDX_W-1:0] rd_idx,
  input  logic                           commit,
  input  sst_pkg::sst_data_t             upd
);
  import sst_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  sst_data_t        mem [SLOTS];
  logic [SLOTS-1:0] valid_r;
  sst_data_t        rd_data_r;
  logic             rd_live_r;
  logic [IDX_W-1:0] addr_r;
  sst_data_t        old_data;
  sst_data_t        merged;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx[IDX_W-1:0]];
      rd_live_r <= valid_r[rd_idx[IDX_W-1:0]];
      addr_r    <= rd_idx[IDX_W-1:0];
    end
    if (commit) begin
      mem[addr_r] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (commit) begin
      valid_r[addr_r] <= 1'b1;
    end
  end

  // a zero field keeps the stored value; unwritten entries read as zero
  always_comb begin
    old_data           = rd_live_r ? rd_data_r : '0;
    merged             = old_data;
    if (upd.temperature != '0) merged.temperature = upd.temperature;
    if (upd.humidity != '0)    merged.humidity    = upd.humidity;
    if (upd.timestamp != '0)   merged.timestamp   = upd.timestamp;
  end

endmodule

// ===== hw/rtl/sensor_slot_table.sv =====
// Sensor slot table: find-or-allocate of readings keyed by a 16-bit device id.
//
// Input channel in_ch carries one update or delete item per beat; result
// channel out_ch returns exactly one beat per item with a status code and the
// slot touched (zero when none was).
// An item passes through accept, compare against every slot id, priority
// encode with the reading RAM read and id write, then reading write-back
// and result load. in_ch.ready is high only while no item is in flight, so
// a new item is taken only after the previous one has loaded its result.
// The result register sits apart from the input side: a new item
// is accepted while the previous result still waits, and the write-back stage
// holds only if that result is still untaken when the next one is ready.
// Ids live in compare cells; temperature, humidity and timestamp live in one
// single-port RAM read and written back on the same slot. Items never overlap,
// so a slot read always sees the previous item's write.
// Synchronous reset clears all ids to free and marks every reading entry
// unwritten (read as zero); no clearing pass is needed, the block is ready for
// an item as soon as reset is released.
module sensor_slot_table #(
  parameter int SLOTS = sst_pkg::SLOTS_DEF
) (
  input logic   clk,
  input logic   rst_n,
  sst_in_if.sink    in_ch,
  sst_out_if.source out_ch
);
  import sst_pkg::*;

  sst_state_t            state_r, state_nxt;
  sst_item_t             item_r;
  sst_status_t           status_r, status_nxt;
  logic [SLOT_IDX_W-1:0] slot_r, slot_nxt;
  logic                  touch_r, touch_nxt;
  logic                  out_valid_r, out_valid_nxt;
  sst_status_t           out_status_r;
  logic [SLOT_IDX_W-1:0] out_slot_r;
  logic                  in_fire;
  logic                  out_load;
  logic                  commit;
  sst_lookup_t           lookup;
  sst_id_wr_t            id_wr;
  sst_data_t             upd;

  assign in_fire = in_ch.valid && in_ch.ready;

  sst_slot_ids #(.SLOTS(SLOTS)) u_ids (
    .clk    (clk),
    .rst_n  (rst_n),
    .key    (item_r.device_id),
    .id_wr  (id_wr),
    .lookup (lookup)
  );

  assign upd.temperature = item_r.temperature_centi;
  assign upd.humidity    = item_r.humidity_centi;
  assign upd.timestamp   = item_r.timestamp;

  sst_slot_data #(.SLOTS(SLOTS)) u_data (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (state_r == S_RESOLVE && touch_nxt),
    .rd_idx (slot_nxt),
    .commit (commit),
    .upd    (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.command           <= in_ch.command;
      item_r.device_id         <= in_ch.device_id;
      item_r.new_id            <= in_ch.new_id;
      item_r.temperature_centi <= in_ch.temperature_centi;
      item_r.humidity_centi    <= in_ch.humidity_centi;
      item_r.timestamp         <= in_ch.timestamp;
    end
    if (state_r == S_RESOLVE) begin
      status_r <= status_nxt;
      slot_r   <= slot_nxt;
      touch_r  <= touch_nxt;
    end
    if (out_load) begin
      out_status_r <= status_r;
      out_slot_r   <= slot_r;
    end
  end

  // resolve: lowest match, else lowest free slot on update
  always_comb begin
    status_nxt = STAT_FULL;
    slot_nxt   = '0;
    touch_nxt  = 1'b0;
    id_wr      = '0;
    if (item_r.command == CMD_DELETE) begin
      if (lookup.hit) begin
        status_nxt = STAT_DELETED;
        slot_nxt   = lookup.hit_idx;
        id_wr.en   = 1'b1;
        id_wr.idx  = lookup.hit_idx;
        id_wr.id   = '0;
      end else begin
        status_nxt = STAT_NOT_FOUND;
      end
    end else if (lookup.hit) begin
      status_nxt = STAT_UPDATED;
      slot_nxt   = lookup.hit_idx;
      touch_nxt  = 1'b1;
      id_wr.en   = (item_r.new_id != '0);
      id_wr.idx  = lookup.hit_idx;
      id_wr.id   = item_r.new_id;
    end else if (lookup.free) begin
      status_nxt = STAT_ADDED;
      slot_nxt   = lookup.free_idx;
      touch_nxt  = 1'b1;
      id_wr.en   = 1'b1;
      id_wr.idx  = lookup.free_idx;
      id_wr.id   = (item_r.new_id != '0) ? item_r.new_id : item_r.device_id;
    end
    if (state_r != S_RESOLVE) begin
      id_wr.en = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        state_nxt = S_RESOLVE;
      end
      S_RESOLVE: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign commit = out_load && touch_r;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot_index = out_slot_r;

endmodule

// ===== hw/rtl/sst_checker.sv =====
// Port-level checks for the sensor slot table, bound to the top level.
module sst_checker #(
  parameter int SLOTS = sst_pkg::SLOTS_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [sst_pkg::STATUS_W-1:0]   out_status,
  input logic [sst_pkg::SLOT_IDX_W-1:0] out_slot_index
);
  import sst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_slot_index))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STAT_UPDATED || out_status == STAT_ADDED ||
                  out_status == STAT_FULL || out_status == STAT_DELETED ||
                  out_status == STAT_NOT_FOUND)
    else $error("undefined status code");

  a_no_slot_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL || out_status == STAT_NOT_FOUND)
    |-> out_slot_index == '0)
    else $error("slot reported for an item that touched none");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_slot_index) < SLOTS)
    else $error("slot index beyond table");

endmodule

bind sensor_slot_table sst_checker #(.SLOTS(SLOTS)) u_sst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_status     (out_ch.status),
  .out_slot_index (out_ch.slot_index)
);

// ===== tb/sv/sst_tb_pkg.sv =====
`timescale 1ns / 100ps
// Slot table tracker: predicts the result beat of each accepted item and checks the result channel.
package sst_tb_pkg;
  import sst_pkg::*;

  typedef struct packed {
    sst_status_t           status;
    logic [SLOT_IDX_W-1:0] slot_index;
  } sst_result_t;

  class sst_tracker;
    // readings never reach the result channel, so only the ids are tracked
    logic [ID_W-1:0] ids [SLOTS_DEF];
    sst_result_t     due_results [$];
    int              errors;

    function new();
      foreach (ids[i]) ids[i] = '0;
      errors = 0;
    endfunction

    function int first_slot(logic [ID_W-1:0] key);
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (ids[i] == key) return i;
      end
      return -1;
    endfunction

    function logic [ID_W-1:0] some_id();
      return ids[$urandom_range(0, SLOTS_DEF - 1)];
    endfunction

    function void log_item(sst_item_t it);
      int          slot;
      sst_result_t res;
      slot = first_slot(it.device_id);
      if (it.command == CMD_DELETE) begin
        if (slot >= 0) begin
          ids[slot]  = '0;
          res.status = STAT_DELETED;
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end else begin
        res.status = STAT_UPDATED;
        if (slot < 0) begin
          slot = first_slot('0);
          if (slot >= 0) begin
            ids[slot]  = it.device_id;
            res.status = STAT_ADDED;
          end else begin
            res.status = STAT_FULL;
          end
        end
        if (slot >= 0 && it.new_id != '0) ids[slot] = it.new_id;
      end
      res.slot_index = (slot >= 0) ? SLOT_IDX_W'(slot) : '0;
      due_results.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task match_result(logic [STATUS_W-1:0] status, logic [SLOT_IDX_W-1:0] slot_index);
      sst_result_t res;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected beat, status %0d slot %0d", status, slot_index));
        return;
      end
      res = due_results.pop_front();
      if (status !== res.status)
        report($sformatf("status %0d, expected %0d", status, res.status));
      if (slot_index !== res.slot_index)
        report($sformatf("slot_index %0d, expected %0d", slot_index, res.slot_index));
    endtask

    function int pending();
      return due_results.size();
    endfunction

    task close();
      if (due_results.size() != 0)
        report($sformatf("%0d results never arrived", due_results.size()));
    endtask
  endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Top-level testbench: directed and random update/delete beats through the sensor slot table.
module testbench;
  import sst_pkg::*;
  import sst_tb_pkg::*;

  localparam int ITEMS       = 1350;
  localparam int QUIET_TAIL  = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 80;
  localparam int ID_POOL     = 24;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sst_in_if  in_ch ();
  sst_out_if out_ch ();

  sensor_slot_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sst_tracker tracker = new();
  int sent      = 0;
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit quiet_tail();
    return sent >= ITEMS - QUIET_TAIL;
  endfunction

  function automatic sst_item_t mk(sst_cmd_t cmd, logic [ID_W-1:0] dev, logic [ID_W-1:0] nid,
                                   logic signed [TEMP_W-1:0] temp, logic [HUM_W-1:0] hum,
                                   logic [TS_W-1:0] ts);
    sst_item_t it;
    it.command           = cmd;
    it.device_id         = dev;
    it.new_id            = nid;
    it.temperature_centi = temp;
    it.humidity_centi    = hum;
    it.timestamp         = ts;
    return it;
  endfunction

  function automatic sst_item_t random_item(int del_pct);
    sst_item_t it;
    int        pick;
    it.command = ($urandom_range(0, 99) < del_pct) ? CMD_DELETE : CMD_UPDATE;
    pick = $urandom_range(0, 19);
    if (pick < 12)      it.device_id = ID_W'($urandom_range(1, ID_POOL));
    else if (pick < 16) it.device_id = tracker.some_id();
    else if (pick < 17) it.device_id = '0;
    else                it.device_id = ID_W'($urandom);
    pick = $urandom_range(0, 19);
    if (pick < 14)      it.new_id = '0;
    else if (pick < 19) it.new_id = ID_W'($urandom_range(1, ID_POOL));
    else                it.new_id = ID_W'($urandom);
    it.temperature_centi = ($urandom_range(0, 3) == 0) ? '0 : TEMP_W'($urandom);
    it.humidity_centi    = ($urandom_range(0, 3) == 0) ? '0 : HUM_W'($urandom);
    it.timestamp         = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_item(sst_item_t it);
    int gap;
    gap = 0;
    if (!quiet_tail() && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.command           <= it.command;
    in_ch.device_id         <= it.device_id;
    in_ch.new_id            <= it.new_id;
    in_ch.temperature_centi <= it.temperature_centi;
    in_ch.humidity_centi    <= it.humidity_centi;
    in_ch.timestamp         <= it.timestamp;
    in_ch.valid             <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.log_item(it);
    sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      tracker.match_result(out_ch.status, out_ch.slot_index);
  end

  // result side: short random stalls, one long hold-off to back the block up
  initial begin
    int   hold;
    logic next_ready;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        next_ready = 1'b0;
      end else if (!hold_done && sent >= HOLD_AT) begin
        hold_done  = 1'b1;
        hold       = HOLD_CYCLES - 1;
        next_ready = 1'b0;
      end else if (!quiet_tail() && $urandom_range(0, 99) < stall_pct) begin
        hold       = $urandom_range(0, 2);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      out_ch.ready <= next_ready;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL sensor_slot_table");
    $finish;
  end

  initial begin
    int del_pct;
    in_ch.valid             = 1'b0;
    in_ch.command           = CMD_UPDATE;
    in_ch.device_id         = '0;
    in_ch.new_id            = '0;
    in_ch.temperature_centi = '0;
    in_ch.humidity_centi    = '0;
    in_ch.timestamp         = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // id zero matches a free slot; delete of it leaves it free
    send_item(mk(CMD_UPDATE, '0, '0, '0, '0, '0));
    send_item(mk(CMD_DELETE, '0, '0, '0, '0, '0));
    send_item(mk(CMD_DELETE, 16'hFFFF, '0, '0, '0, '0));
    send_item(mk(CMD_UPDATE, 16'hFFFF, 16'hFFFF, 16'sh7FFF, 14'h3FFF, 32'hFFFF_FFFF));
    send_item(mk(CMD_UPDATE, 16'hFFFF, '0, 16'sh8000, 14'd10000, 32'd1));
    // add with a new id that another slot already holds
    send_item(mk(CMD_UPDATE, 16'h0001, 16'hFFFF, -16'sd1, 14'd1, '0));
    send_item(mk(CMD_DELETE, 16'hFFFF, 16'h1234, 16'sd5, 14'd5, 32'd5));
    send_item(mk(CMD_UPDATE, 16'hFFFF, '0, '0, '0, '0));
    for (int k = 2; k <= 16; k++)
      send_item(mk(CMD_UPDATE, ID_W'(k), '0, TEMP_W'($urandom), HUM_W'($urandom), $urandom));
    send_item(mk(CMD_UPDATE, 16'd17, 16'd18, 16'sd1, 14'd1, 32'd1));
    send_item(mk(CMD_DELETE, 16'd9, '0, '0, '0, '0));

    del_pct = 30;
    for (int n = 0; n < ITEMS; n++) begin
      if (n % 100 == 0) begin
        del_pct   = $urandom_range(10, 55);
        idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end
      send_item(random_item(del_pct));
    end
    in_ch.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    tracker.close();
    if (tracker.errors == 0)
      $display("PASS sensor_slot_table");
    else
      $display("FAIL sensor_slot_table");
    $finish;
  end

endmodule
